// File: hw/rtl/plue_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak-level utterance endpointer package
// Shared constants, sample format codes, register map and stage types.
// ----------------------------------------------------------------------------
package plue_pkg;

  // Sample format codes; the two codes above FMT_U32 measure nothing.
  localparam logic [2:0] FMT_S8  = 3'd0;
  localparam logic [2:0] FMT_S16 = 3'd1;
  localparam logic [2:0] FMT_S32 = 3'd2;
  localparam logic [2:0] FMT_U8  = 3'd3;
  localparam logic [2:0] FMT_U16 = 3'd4;
  localparam logic [2:0] FMT_U32 = 3'd5;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_FORMAT    = 3'd0;
  localparam logic [2:0] REG_THRESHOLD = 3'd1;
  localparam logic [2:0] REG_MAX_BUF   = 3'd2;
  localparam logic [2:0] REG_MIN_LOUD  = 3'd3;
  localparam logic [2:0] REG_QUIET_RUN = 3'd4;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // Reset values of the registers.
  localparam logic [2:0]  RST_FORMAT    = FMT_S16;
  localparam logic [15:0] RST_THRESHOLD = 16'd22938;
  localparam logic [9:0]  RST_MAX_BUF   = 10'd150;
  localparam logic [9:0]  RST_MIN_LOUD  = 10'd2;
  localparam logic [9:0]  RST_QUIET_RUN = 10'd12;

  // Buffer counters saturate at their full range.
  localparam int unsigned  CNT_W   = 11;
  localparam logic [10:0]  CNT_MAX = 11'h7FF;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned LEVEL_W  = 16;

  // Register file contents as seen by the datapath.
  typedef struct packed {
    logic [2:0]  fmt;
    logic [15:0] threshold;
    logic [9:0]  max_buf;
    logic [9:0]  min_loud;
    logic [9:0]  quiet_run;
  } cfg_t;

  // Measure stage word: value folded into the peak, and the buffer end flag.
  typedef struct packed {
    logic [SAMPLE_W-1:0] mag;
    logic                last;
  } meas_t;

  // Level stage word.
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               last;
  } lvl_t;

endpackage

// File: hw/rtl/plue_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file for format, threshold and the buffer limits.
// ----------------------------------------------------------------------------
module plue_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [plue_pkg::ADDR_W-1:0] paddr,
  input  logic [plue_pkg::DATA_W-1:0] pwdata,
  output logic [plue_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output plue_pkg::cfg_t              cfg
);

  plue_pkg::cfg_t cfg_r;
  logic           wr_en;
  logic [2:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg     = cfg_r;

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fmt       <= plue_pkg::RST_FORMAT;
      cfg_r.threshold <= plue_pkg::RST_THRESHOLD;
      cfg_r.max_buf   <= plue_pkg::RST_MAX_BUF;
      cfg_r.min_loud  <= plue_pkg::RST_MIN_LOUD;
      cfg_r.quiet_run <= plue_pkg::RST_QUIET_RUN;
    end else if (wr_en) begin
      unique case (reg_idx)
        plue_pkg::REG_FORMAT:    cfg_r.fmt       <= pwdata[2:0];
        plue_pkg::REG_THRESHOLD: cfg_r.threshold <= pwdata[15:0];
        plue_pkg::REG_MAX_BUF:   cfg_r.max_buf   <= pwdata[9:0];
        plue_pkg::REG_MIN_LOUD:  cfg_r.min_loud  <= pwdata[9:0];
        plue_pkg::REG_QUIET_RUN: cfg_r.quiet_run <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // Read data.
  always_comb begin
    unique case (reg_idx)
      plue_pkg::REG_FORMAT:    prdata = 32'(cfg_r.fmt);
      plue_pkg::REG_THRESHOLD: prdata = 32'(cfg_r.threshold);
      plue_pkg::REG_MAX_BUF:   prdata = 32'(cfg_r.max_buf);
      plue_pkg::REG_MIN_LOUD:  prdata = 32'(cfg_r.min_loud);
      plue_pkg::REG_QUIET_RUN: prdata = 32'(cfg_r.quiet_run);
      default:                 prdata = '0;
    endcase
  end

endmodule

// File: hw/rtl/plue_measure.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample measure stage
// Input register that holds the magnitude (signed) or raw value (unsigned).
// ----------------------------------------------------------------------------
module plue_measure (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [plue_pkg::SAMPLE_W-1:0] in_sample,
  input  logic [2:0]                    in_channel,
  input  logic                          in_last_of_buffer,
  input  logic [2:0]                    fmt,
  output logic                          a_valid,
  input  logic                          a_ready,
  output plue_pkg::meas_t               a_word
);

  logic                          a_valid_r;
  plue_pkg::meas_t               a_word_r;
  logic [plue_pkg::SAMPLE_W-1:0] mag_nxt;
  logic [8:0]                    neg8;
  logic [16:0]                   neg16;

  assign in_ready = !a_valid_r || a_ready;
  assign a_valid  = a_valid_r;
  assign a_word   = a_word_r;

  // Two's complement magnitudes of the narrow signed formats.
  assign neg8  = 9'h100 - {1'b0, in_sample[7:0]};
  assign neg16 = 17'h10000 - {1'b0, in_sample[15:0]};

  // Value folded into the peak; only channel 0 is measured.
  always_comb begin
    unique case (fmt)
      plue_pkg::FMT_S8:  mag_nxt = in_sample[7] ? 32'(neg8) : 32'(in_sample[7:0]);
      plue_pkg::FMT_S16: mag_nxt = in_sample[15] ? 32'(neg16) : 32'(in_sample[15:0]);
      plue_pkg::FMT_S32: mag_nxt = in_sample[31] ? (32'd0 - in_sample) : in_sample;
      plue_pkg::FMT_U8:  mag_nxt = 32'(in_sample[7:0]);
      plue_pkg::FMT_U16: mag_nxt = 32'(in_sample[15:0]);
      plue_pkg::FMT_U32: mag_nxt = in_sample;
      default:           mag_nxt = '0;
    endcase
    if (in_channel != 3'd0) begin
      mag_nxt = '0;
    end
  end

  // Stage valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ready) begin
      a_valid_r <= in_valid;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_word_r.mag  <= mag_nxt;
      a_word_r.last <= in_last_of_buffer;
    end
  end

endmodule

// File: hw/rtl/plue_peak.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running peak and level stage
// Folds each word into the buffer peak and passes on the peak's normalized level.
// ----------------------------------------------------------------------------
module plue_peak (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [2:0]      fmt,
  input  logic            a_valid,
  output logic            a_ready,
  input  plue_pkg::meas_t a_word,
  output logic            b_valid,
  input  logic            b_ready,
  output plue_pkg::lvl_t  b_word
);

  logic                          b_valid_r;
  plue_pkg::lvl_t                b_word_r;
  logic [plue_pkg::SAMPLE_W-1:0] peak_r;
  logic [plue_pkg::SAMPLE_W-1:0] peak_fold;
  logic                          a_fire;

  // Q0.16 level of a peak. Full scale is 2^k - 1, so for values below full
  // scale the quotient is the k-bit value repeated as a binary fraction.
  function automatic logic [plue_pkg::LEVEL_W-1:0] normalize(
    input logic [2:0]                    f,
    input logic [plue_pkg::SAMPLE_W-1:0] pk
  );
    logic [32:0] p;
    logic [32:0] twice;
    logic [32:0] num;
    logic [20:0] rep7;
    logic [29:0] rep15;
    logic [plue_pkg::LEVEL_W-1:0] lvl;
    twice = {pk, 1'b0};
    unique case (f)
      plue_pkg::FMT_S8:  p = 33'd127;
      plue_pkg::FMT_S16: p = 33'd32767;
      plue_pkg::FMT_S32: p = 33'h07FFFFFFF;
      plue_pkg::FMT_U8:  p = 33'd255;
      plue_pkg::FMT_U16: p = 33'd65535;
      plue_pkg::FMT_U32: p = 33'h0FFFFFFFF;
      default:           p = '0;
    endcase
    // Unsigned formats measure the distance from mid-scale.
    if (f == plue_pkg::FMT_U8 || f == plue_pkg::FMT_U16 || f == plue_pkg::FMT_U32) begin
      num = (twice >= p) ? (twice - p) : (p - twice);
    end else begin
      num = {1'b0, pk};
    end
    rep7  = {num[6:0], num[6:0], num[6:0]};
    rep15 = {num[14:0], num[14:0]};
    unique case (f)
      plue_pkg::FMT_S8:  lvl = rep7[20:5];
      plue_pkg::FMT_S16: lvl = rep15[29:14];
      plue_pkg::FMT_S32: lvl = num[30:15];
      plue_pkg::FMT_U8:  lvl = {num[7:0], num[7:0]};
      plue_pkg::FMT_U16: lvl = num[15:0];
      plue_pkg::FMT_U32: lvl = num[31:16];
      default:           lvl = '0;
    endcase
    // At or above full scale the level saturates.
    if (p != 33'd0 && num >= p) begin
      lvl = '1;
    end
    return lvl;
  endfunction

  assign a_ready   = !b_valid_r || b_ready;
  assign a_fire    = a_valid && a_ready;
  assign b_valid   = b_valid_r;
  assign b_word    = b_word_r;
  assign peak_fold = (a_word.mag > peak_r) ? a_word.mag : peak_r;

  // Running peak, cleared at every buffer end.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= '0;
    end else if (a_fire) begin
      peak_r <= a_word.last ? '0 : peak_fold;
    end
  end

  // Stage valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (a_ready) begin
      b_valid_r <= a_valid;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (a_fire) begin
      b_word_r.level <= normalize(fmt, peak_fold);
      b_word_r.last  <= a_word.last;
    end
  end

endmodule

// File: hw/rtl/plue_decide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Endpoint decision stage
// Threshold compare, buffer counters and the registered result word.
// ----------------------------------------------------------------------------
module plue_decide (
  input  logic                         clk,
  input  logic                         rst_n,
  input  plue_pkg::cfg_t               cfg,
  input  logic                         b_valid,
  output logic                         b_ready,
  input  plue_pkg::lvl_t               b_word,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [plue_pkg::LEVEL_W-1:0] out_level,
  output logic                         out_loud,
  output logic                         out_stop_recording,
  output logic                         out_speech_detected,
  output logic [plue_pkg::CNT_W-1:0]   out_buffer_index
);

  logic [plue_pkg::CNT_W-1:0]   buf_cnt_r, buf_cnt_nxt;
  logic [plue_pkg::CNT_W-1:0]   loud_cnt_r, loud_cnt_nxt;
  logic [plue_pkg::CNT_W-1:0]   quiet_cnt_r, quiet_cnt_nxt;
  logic                         out_valid_r;
  logic [plue_pkg::LEVEL_W-1:0] out_level_r;
  logic                         out_loud_r;
  logic                         out_stop_r;
  logic                         out_speech_r;
  logic [plue_pkg::CNT_W-1:0]   out_index_r;
  logic                         loud;
  logic                         stop;
  logic                         speech;
  logic                         enough_loud;
  logic                         b_take;
  logic                         decide;

  function automatic logic [plue_pkg::CNT_W-1:0] sat_inc(
    input logic [plue_pkg::CNT_W-1:0] v
  );
    return (v == plue_pkg::CNT_MAX) ? v : v + 1'b1;
  endfunction

  // Words that end no buffer drain without touching the result register.
  assign b_ready = !b_word.last || !out_valid_r || out_ready;
  assign b_take  = b_valid && b_ready;
  assign decide  = b_take && b_word.last;

  // Counter update and stop decision.
  always_comb begin
    loud         = b_word.level >= cfg.threshold;
    buf_cnt_nxt  = sat_inc(buf_cnt_r);
    if (loud) begin
      loud_cnt_nxt  = sat_inc(loud_cnt_r);
      quiet_cnt_nxt = '0;
    end else begin
      loud_cnt_nxt  = loud_cnt_r;
      quiet_cnt_nxt = sat_inc(quiet_cnt_r);
    end
    enough_loud = loud_cnt_nxt >= {1'b0, cfg.min_loud};
    if (buf_cnt_nxt <= {1'b0, cfg.max_buf}) begin
      stop   = enough_loud && (quiet_cnt_nxt >= {1'b0, cfg.quiet_run});
      speech = stop;
    end else begin
      stop   = 1'b1;
      speech = enough_loud;
    end
  end

  // Counters; a stop starts a new recording.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_cnt_r   <= '0;
      loud_cnt_r  <= '0;
      quiet_cnt_r <= '0;
    end else if (decide) begin
      buf_cnt_r   <= stop ? '0 : buf_cnt_nxt;
      loud_cnt_r  <= stop ? '0 : loud_cnt_nxt;
      quiet_cnt_r <= stop ? '0 : quiet_cnt_nxt;
    end
  end

  // Result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (decide) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result word.
  always_ff @(posedge clk) begin
    if (decide) begin
      out_level_r  <= b_word.level;
      out_loud_r   <= loud;
      out_stop_r   <= stop;
      out_speech_r <= speech;
      out_index_r  <= buf_cnt_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_level           = out_level_r;
  assign out_loud            = out_loud_r;
  assign out_stop_recording  = out_stop_r;
  assign out_speech_detected = out_speech_r;
  assign out_buffer_index    = out_index_r;

endmodule

// File: hw/rtl/peak_level_utterance_endpointer_top.sv
`timescale 1ns / 1ps
// Each result word is registered by the decision stage from the buffer's last word.
// Throughput: one sample word per cycle; the three stages (measure, peak/level,
// decision) each hold one word and stall only when the result register is held.
// Reset (synchronous, active low) empties the pipeline, clears the running peak
// and the buffer counters, and loads the register reset values.
// ----------------------------------------------------------------------------
// Peak-level utterance endpointer
// Tracks the channel 0 peak per buffer and decides when an utterance ends.
// ----------------------------------------------------------------------------
module peak_level_utterance_endpointer_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [plue_pkg::SAMPLE_W-1:0] in_sample,
  input  logic [2:0]                    in_channel,
  input  logic                          in_last_of_buffer,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [plue_pkg::LEVEL_W-1:0]  out_level,
  output logic                          out_loud,
  output logic                          out_stop_recording,
  output logic                          out_speech_detected,
  output logic [plue_pkg::CNT_W-1:0]    out_buffer_index,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [plue_pkg::ADDR_W-1:0]   paddr,
  input  logic [plue_pkg::DATA_W-1:0]   pwdata,
  output logic [plue_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  plue_pkg::cfg_t  cfg;
  logic            a_valid;
  logic            a_ready;
  plue_pkg::meas_t a_word;
  logic            b_valid;
  logic            b_ready;
  plue_pkg::lvl_t  b_word;

  // Register file.
  plue_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input register with sample measurement.
  plue_measure u_measure (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample         (in_sample),
    .in_channel        (in_channel),
    .in_last_of_buffer (in_last_of_buffer),
    .fmt               (cfg.fmt),
    .a_valid           (a_valid),
    .a_ready           (a_ready),
    .a_word            (a_word)
  );

  // Running peak and level.
  plue_peak u_peak (
    .clk     (clk),
    .rst_n   (rst_n),
    .fmt     (cfg.fmt),
    .a_valid (a_valid),
    .a_ready (a_ready),
    .a_word  (a_word),
    .b_valid (b_valid),
    .b_ready (b_ready),
    .b_word  (b_word)
  );

  // Decision and result register.
  plue_decide u_decide (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg),
    .b_valid             (b_valid),
    .b_ready             (b_ready),
    .b_word              (b_word),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_level           (out_level),
    .out_loud            (out_loud),
    .out_stop_recording  (out_stop_recording),
    .out_speech_detected (out_speech_detected),
    .out_buffer_index    (out_buffer_index)
  );

endmodule

// File: hw/rtl/plue_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Endpointer port checker
// Watches the result port of the top level over time.
// ----------------------------------------------------------------------------
module plue_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [plue_pkg::LEVEL_W-1:0] out_level,
  input logic                         out_loud,
  input logic                         out_stop_recording,
  input logic                         out_speech_detected,
  input logic [plue_pkg::CNT_W-1:0]   out_buffer_index
);

  // A held result word keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_level) && $stable(out_loud) &&
      $stable(out_stop_recording) && $stable(out_speech_detected) &&
      $stable(out_buffer_index))
    else $error("result word changed while stalled");

  // Speech is only reported on a stop.
  a_speech: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stop_recording |-> !out_speech_detected)
    else $error("speech flagged without stop");

  // Every result counts at least its own buffer.
  a_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_buffer_index != '0)
    else $error("buffer index is zero");

  // The word right after a delivered stop opens a new recording.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_stop_recording |=> !out_valid || out_buffer_index == 11'd1)
    else $error("recording not restarted after stop");

  // Reset empties the result register.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind peak_level_utterance_endpointer_top plue_checker u_plue_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_level           (out_level),
  .out_loud            (out_loud),
  .out_stop_recording  (out_stop_recording),
  .out_speech_detected (out_speech_detected),
  .out_buffer_index    (out_buffer_index)
);

// File: sim/peak_level_utterance_endpointer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak-level utterance endpointer testbench
// Streams audio sample words through the endpointer and checks every buffer
// result against a cycle-free predictor of the peak, level and stop logic.
// Directed buffers cover the format extremes, other channels, a format change
// inside a buffer and zero limits; random phases mix register settings and
// idling on both channels.
// ----------------------------------------------------------------------------
module peak_level_utterance_endpointer_top_tb;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned RANDOM_SAMPLES = 1400;
  localparam int unsigned PHASE_SAMPLES  = 100;

  // One buffer result word as the block reports it.
  typedef struct packed {
    logic [plue_pkg::LEVEL_W-1:0] level;
    logic                         loud;
    logic                         stop;
    logic                         speech;
    logic [plue_pkg::CNT_W-1:0]   index;
  } verdict_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [plue_pkg::SAMPLE_W-1:0] in_sample = '0;
  logic [2:0]                    in_channel = '0;
  logic                          in_last_of_buffer = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [plue_pkg::LEVEL_W-1:0]  out_level;
  logic                          out_loud;
  logic                          out_stop_recording;
  logic                          out_speech_detected;
  logic [plue_pkg::CNT_W-1:0]    out_buffer_index;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [plue_pkg::ADDR_W-1:0]   paddr = '0;
  logic [plue_pkg::DATA_W-1:0]   pwdata = '0;
  logic [plue_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  // Predictor copy of the registers and the buffer state.
  logic [2:0]                    cur_fmt = plue_pkg::RST_FORMAT;
  logic [15:0]                   cur_threshold = plue_pkg::RST_THRESHOLD;
  logic [9:0]                    cur_max_buf = plue_pkg::RST_MAX_BUF;
  logic [9:0]                    cur_min_loud = plue_pkg::RST_MIN_LOUD;
  logic [9:0]                    cur_quiet_run = plue_pkg::RST_QUIET_RUN;
  logic [plue_pkg::SAMPLE_W-1:0] peak_so_far = '0;
  logic [plue_pkg::CNT_W-1:0]    buffers_seen = '0;
  logic [plue_pkg::CNT_W-1:0]    loud_seen = '0;
  logic [plue_pkg::CNT_W-1:0]    quiet_run_seen = '0;

  verdict_t verdict_q[$];

  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned n_samples = 0;
  int unsigned n_checked = 0;
  int unsigned n_stops = 0;
  int unsigned n_bad = 0;
  int unsigned n_phases = 0;
  int unsigned quiet_cycles = 0;

  peak_level_utterance_endpointer_top uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_sample           (in_sample),
    .in_channel          (in_channel),
    .in_last_of_buffer   (in_last_of_buffer),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_level           (out_level),
    .out_loud            (out_loud),
    .out_stop_recording  (out_stop_recording),
    .out_speech_detected (out_speech_detected),
    .out_buffer_index    (out_buffer_index),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always #10 clk = ~clk;

  // Value folded into the peak: magnitude for signed codes, raw value otherwise.
  function automatic logic [plue_pkg::SAMPLE_W-1:0] sample_magnitude(
    logic [2:0] fmt, logic [plue_pkg::SAMPLE_W-1:0] raw);
    case (fmt)
      plue_pkg::FMT_S8:  return raw[7] ? 32'h100 - {24'd0, raw[7:0]} : {24'd0, raw[7:0]};
      plue_pkg::FMT_S16: return raw[15] ? 32'h10000 - {16'd0, raw[15:0]} : {16'd0, raw[15:0]};
      plue_pkg::FMT_S32: return raw[31] ? 32'd0 - raw : raw;
      plue_pkg::FMT_U8:  return {24'd0, raw[7:0]};
      plue_pkg::FMT_U16: return {16'd0, raw[15:0]};
      plue_pkg::FMT_U32: return raw;
      default: return '0;
    endcase
  endfunction

  function automatic logic [63:0] full_scale(logic [2:0] fmt);
    case (fmt)
      plue_pkg::FMT_S8:  return 64'd127;
      plue_pkg::FMT_S16: return 64'd32767;
      plue_pkg::FMT_S32: return 64'd2147483647;
      plue_pkg::FMT_U8:  return 64'd255;
      plue_pkg::FMT_U16: return 64'd65535;
      plue_pkg::FMT_U32: return 64'd4294967295;
      default: return 64'd0;
    endcase
  endfunction

  // Peak as a Q0.16 fraction of full scale; unsigned codes measure from mid-scale.
  function automatic logic [plue_pkg::LEVEL_W-1:0] peak_to_level(
    logic [2:0] fmt, logic [plue_pkg::SAMPLE_W-1:0] peak);
    logic [63:0] fs;
    logic [63:0] num;
    logic [63:0] q;
    fs = full_scale(fmt);
    if (fs == 64'd0) return '0;
    if (fmt <= plue_pkg::FMT_S32) begin
      num = {32'd0, peak};
    end else begin
      num = {31'd0, peak, 1'b0};
      num = (num >= fs) ? num - fs : fs - num;
    end
    q = (num << 16) / fs;
    return (q > 64'd65535) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic logic [plue_pkg::CNT_W-1:0] count_up(logic [plue_pkg::CNT_W-1:0] v);
    return (v == plue_pkg::CNT_MAX) ? v : v + 1'b1;
  endfunction

  // Fold one accepted sample word into the peak and decide at the buffer end.
  task automatic fold_and_decide(logic [plue_pkg::SAMPLE_W-1:0] raw, logic [2:0] ch,
                                 logic lst);
    verdict_t v;
    logic [plue_pkg::SAMPLE_W-1:0] m;
    if (ch == 3'd0) begin
      m = sample_magnitude(cur_fmt, raw);
      if (m > peak_so_far) peak_so_far = m;
    end
    if (lst) begin
      v.level = peak_to_level(cur_fmt, peak_so_far);
      peak_so_far = '0;
      v.loud = (v.level >= cur_threshold);
      buffers_seen = count_up(buffers_seen);
      if (v.loud) begin
        loud_seen = count_up(loud_seen);
        quiet_run_seen = '0;
      end else begin
        quiet_run_seen = count_up(quiet_run_seen);
      end
      v.stop = 1'b0;
      v.speech = 1'b0;
      if (buffers_seen <= {1'b0, cur_max_buf}) begin
        if (loud_seen >= {1'b0, cur_min_loud} && quiet_run_seen >= {1'b0, cur_quiet_run}) begin
          v.stop = 1'b1;
          v.speech = 1'b1;
        end
      end else begin
        v.stop = 1'b1;
        v.speech = (loud_seen >= {1'b0, cur_min_loud});
      end
      v.index = buffers_seen;
      if (v.stop) begin
        buffers_seen = '0;
        loud_seen = '0;
        quiet_run_seen = '0;
      end
      verdict_q.push_back(v);
    end
  endtask

  // Send one sample word; valid stays high across back-to-back words.
  task automatic send_word(logic [plue_pkg::SAMPLE_W-1:0] raw, logic [2:0] ch, logic lst);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= raw;
    in_channel <= ch;
    in_last_of_buffer <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_samples++;
    fold_and_decide(raw, ch, lst);
  endtask

  // Drop valid, collect every pending result and let the pipeline empty.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write: setup phase, then access phase until pready, then back to idle.
  task automatic reg_write(logic [2:0] idx, logic [plue_pkg::DATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      plue_pkg::REG_FORMAT:    cur_fmt = val[2:0];
      plue_pkg::REG_THRESHOLD: cur_threshold = val[15:0];
      plue_pkg::REG_MAX_BUF:   cur_max_buf = val[9:0];
      plue_pkg::REG_MIN_LOUD:  cur_min_loud = val[9:0];
      plue_pkg::REG_QUIET_RUN: cur_quiet_run = val[9:0];
      default: ;
    endcase
  endtask

  task automatic set_limits(logic [15:0] thr, logic [9:0] max_buf,
                            logic [9:0] min_loud, logic [9:0] quiet_run);
    reg_write(plue_pkg::REG_THRESHOLD, {16'd0, thr});
    reg_write(plue_pkg::REG_MAX_BUF, {22'd0, max_buf});
    reg_write(plue_pkg::REG_MIN_LOUD, {22'd0, min_loud});
    reg_write(plue_pkg::REG_QUIET_RUN, {22'd0, quiet_run});
  endtask

  // Small excursion around silence for the current format, garbage above it.
  function automatic logic [plue_pkg::SAMPLE_W-1:0] quiet_sample();
    logic [plue_pkg::SAMPLE_W-1:0] k;
    logic [plue_pkg::SAMPLE_W-1:0] junk;
    k = $urandom_range(0, 40);
    if ($urandom_range(1)) k = 32'd0 - k;
    junk = $urandom();
    case (cur_fmt)
      plue_pkg::FMT_S8:  return {junk[31:8], k[7:0]};
      plue_pkg::FMT_S16: return {junk[31:16], k[15:0]};
      plue_pkg::FMT_U8:  return {junk[31:8], 8'h80 + k[7:0]};
      plue_pkg::FMT_U16: return {junk[31:16], 16'h8000 + k[15:0]};
      plue_pkg::FMT_U32: return 32'h8000_0000 + k;
      default: return k;
    endcase
  endfunction

  function automatic logic [plue_pkg::SAMPLE_W-1:0] loud_sample();
    logic [plue_pkg::SAMPLE_W-1:0] r;
    r = $urandom();
    case ($urandom_range(3))
      0: return r;
      1: return {r[31:8], r[7] ? 8'h80 : 8'h7F};
      2: return {r[31:16], r[15] ? 16'h8000 : 16'h7FFF};
      default: begin
        case ($urandom_range(3))
          0: return 32'h0000_0000;
          1: return 32'hFFFF_FFFF;
          2: return 32'h7FFF_FFFF;
          default: return 32'h8000_0000;
        endcase
      end
    endcase
  endfunction

  function automatic logic [9:0] pick_limit(int unsigned hi);
    case ($urandom_range(9))
      0: return 10'd0;
      1: return 10'd1;
      2: return 10'd1023;
      default: return 10'($urandom_range(2, hi));
    endcase
  endfunction

  function automatic logic [15:0] pick_threshold();
    case ($urandom_range(7))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return plue_pkg::RST_THRESHOLD;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // Reset register values: full-scale, most negative and silent s16 words,
  // then other channels and a buffer that never sees channel 0.
  task automatic test_defaults();
    gap_pct = 0;
    stall_pct = 0;
    send_word(32'h0000_7FFF, 3'd0, 1'b1);
    send_word(32'hABCD_8000, 3'd0, 1'b1);
    send_word(32'h0000_0000, 3'd0, 1'b1);
    send_word(32'h0000_7FFF, 3'd3, 1'b0);
    send_word(32'h0000_0010, 3'd0, 1'b0);
    send_word(32'h0000_7FFF, 3'd7, 1'b1);
    send_word(32'hFFFF_8000, 3'd5, 1'b1);
    wait_idle();
  endtask

  // Extreme words for each format code other than s16, the two undefined codes included.
  task automatic test_formats();
    reg_write(plue_pkg::REG_FORMAT, {29'd0, plue_pkg::FMT_S8});
    send_word(32'h1234_5680, 3'd0, 1'b1);
    send_word(32'h0000_007F, 3'd0, 1'b1);
    wait_idle();
    reg_write(plue_pkg::REG_FORMAT, {29'd0, plue_pkg::FMT_S32});
    send_word(32'h8000_0000, 3'd0, 1'b1);
    wait_idle();
    reg_write(plue_pkg::REG_FORMAT, {29'd0, plue_pkg::FMT_U8});
    send_word(32'hFFFF_FF00, 3'd0, 1'b1);
    wait_idle();
    reg_write(plue_pkg::REG_FORMAT, {29'd0, plue_pkg::FMT_U16});
    send_word(32'h0000_8000, 3'd0, 1'b1);
    wait_idle();
    reg_write(plue_pkg::REG_FORMAT, {29'd0, plue_pkg::FMT_U32});
    send_word(32'hFFFF_FFFF, 3'd0, 1'b1);
    wait_idle();
    reg_write(plue_pkg::REG_FORMAT, 32'd6);
    send_word(32'hFFFF_FFFF, 3'd0, 1'b1);
    wait_idle();
    reg_write(plue_pkg::REG_FORMAT, 32'd7);
    send_word(32'h8000_0000, 3'd0, 1'b1);
    wait_idle();
  endtask

  // The peak taken as u8 survives a switch to s8 before the buffer ends.
  task automatic test_format_switch();
    reg_write(plue_pkg::REG_FORMAT, {29'd0, plue_pkg::FMT_U8});
    send_word(32'h0000_00FF, 3'd0, 1'b0);
    wait_idle();
    reg_write(plue_pkg::REG_FORMAT, {29'd0, plue_pkg::FMT_S8});
    send_word(32'h0000_0001, 3'd0, 1'b1);
    wait_idle();
  endtask

  // Zero limits stop on every buffer and count every stop as speech.
  task automatic test_zero_limits();
    reg_write(plue_pkg::REG_FORMAT, {29'd0, plue_pkg::FMT_S16});
    set_limits(16'd0, 10'd0, 10'd0, 10'd0);
    send_word(32'h0000_0000, 3'd0, 1'b1);
    send_word(32'h0000_1000, 3'd0, 1'b1);
    wait_idle();
    set_limits(16'hFFFF, 10'd1023, 10'd0, 10'd0);
    send_word(32'h0000_7FFF, 3'd0, 1'b1);
    send_word(32'h0000_0003, 3'd0, 1'b1);
    wait_idle();
  endtask

  // Random buffers under changing settings and idling mixes.
  task automatic test_random_traffic();
    int unsigned phase_end;
    int unsigned len;
    bit quiet_buf;
    logic [2:0] ch;
    while (n_samples + PHASE_SAMPLES <= RANDOM_SAMPLES) begin
      reg_write(plue_pkg::REG_FORMAT,
                {29'd0, (n_phases < 6) ? 3'(n_phases) : 3'($urandom_range(7))});
      set_limits(pick_threshold(), pick_limit(30), pick_limit(6), pick_limit(8));
      case (n_phases % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 46; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 46; end
        default: begin gap_pct = 11; stall_pct = 11; end
      endcase
      phase_end = n_samples + PHASE_SAMPLES;
      while (n_samples < phase_end) begin
        len = ($urandom_range(15) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
        quiet_buf = ($urandom_range(99) < 55);
        for (int unsigned i = 0; i < len; i++) begin
          ch = ($urandom_range(9) < 7) ? 3'd0 : 3'($urandom_range(7));
          send_word((quiet_buf && $urandom_range(9) != 0) ? quiet_sample() : loud_sample(),
                    ch, i == len - 1);
        end
      end
      wait_idle();
      n_phases++;
    end
  endtask

  // Receiver stalls at random.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic note_mismatch(string what, verdict_t want);
    n_bad++;
    if (n_bad <= 10) begin
      $display("%0t mismatch (%s): expected level=%0d loud=%0b stop=%0b speech=%0b index=%0d",
               $time, what, want.level, want.loud, want.stop, want.speech, want.index);
      $display("%0t           actual   level=%0d loud=%0b stop=%0b speech=%0b index=%0d",
               $time, out_level, out_loud, out_stop_recording, out_speech_detected,
               out_buffer_index);
    end
  endtask

  // Compare each result word with the oldest expected buffer result.
  always @(posedge clk) begin : check_result
    verdict_t want;
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        note_mismatch("unexpected word", '0);
      end else begin
        want = verdict_q.pop_front();
        n_checked++;
        if (want.stop) n_stops++;
        if (out_level !== want.level || out_loud !== want.loud ||
            out_stop_recording !== want.stop || out_speech_detected !== want.speech ||
            out_buffer_index !== want.index) begin
          note_mismatch("field", want);
        end
      end
    end
  end

  // End the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("** peak_level_utterance_endpointer_top: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_formats();
    test_format_switch();
    test_zero_limits();
    test_random_traffic();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d sample words; checked %0d buffer results, %0d of them stops.",
             n_samples, n_checked, n_stops);
    $display("Covered all eight format codes, zero and full limits, %0d random phases.",
             n_phases);
    if (n_bad == 0) begin
      $display("** peak_level_utterance_endpointer_top: PASSED **");
    end else begin
      $display("%0d mismatches in total", n_bad);
      $display("** peak_level_utterance_endpointer_top: FAILED **");
    end
    $finish;
  end

endmodule
